// File: rtl/core/plr_pkg.sv
// Port list range parser: shared constants, phase codes and the result type.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

  localparam int unsigned PLR_PORT_COUNT_DEF = 65536;
  localparam int unsigned RANGE_W            = 16;

  // configuration port
  localparam int unsigned PLR_ADDR_W    = 3;
  localparam int unsigned PLR_DATA_W    = 32;
  localparam logic [0:0]  REG_SEPARATOR = 1'b0;
  localparam logic [7:0]  SEP_RESET     = 8'd44;

  // character codes
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // parse phases
  localparam logic [2:0] PH_INIT     = 3'd0;
  localparam logic [2:0] PH_FIRST    = 3'd1;
  localparam logic [2:0] PH_FIRST_SP = 3'd2;
  localparam logic [2:0] PH_DASH     = 3'd3;
  localparam logic [2:0] PH_LAST     = 3'd4;
  localparam logic [2:0] PH_LAST_SP  = 3'd5;
  localparam logic [2:0] PH_SEP      = 3'd6;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic [RANGE_W-1:0] first;
    logic [RANGE_W-1:0] last;
    logic               valid;
    logic               err;
    logic               done;
  } plr_result_t;

endpackage

`default_nettype wire

// File: rtl/core/plr_apb_regs.sv
// Port list range parser: APB register holding the separator character.
// Depends on plr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plr_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [plr_pkg::PLR_ADDR_W-1:0]  paddr,
  input  wire logic [plr_pkg::PLR_DATA_W-1:0]  pwdata,
  output      logic [plr_pkg::PLR_DATA_W-1:0]  prdata,
  output      logic                            pready,
  output      logic [7:0]                      sep_char_o
);
  import plr_pkg::*;

  logic [7:0] sep_q;
  logic       sel_sep;

  assign sel_sep = (paddr[PLR_ADDR_W-1:2] == REG_SEPARATOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (psel && penable && pwrite && sel_sep) begin
      sep_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_sep) begin
      prdata = PLR_DATA_W'(sep_q);
    end
  end

  assign pready     = 1'b1;
  assign sep_char_o = sep_q;

endmodule

`default_nettype wire

// File: rtl/core/plr_step.sv
// Port list range parser: next-state and result logic for one character.
// Depends on plr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plr_step #(
  parameter int unsigned PORT_COUNT = plr_pkg::PLR_PORT_COUNT_DEF,
  parameter int unsigned ACC_W      = $clog2(PORT_COUNT)
) (
  input  wire logic [2:0]         phase_i,
  input  wire logic [ACC_W-1:0]   sacc_i,
  input  wire logic [ACC_W-1:0]   eacc_i,
  input  wire logic               failed_i,
  input  wire logic [7:0]         char_i,
  input  wire logic               eot_i,
  input  wire logic [7:0]         sep_char_i,
  output      logic [2:0]         phase_o,
  output      logic [ACC_W-1:0]   sacc_o,
  output      logic [ACC_W-1:0]   eacc_o,
  output      logic               failed_o,
  output      logic [1:0]         res_cnt_o,
  output      plr_pkg::plr_result_t res0_o,
  output      plr_pkg::plr_result_t res1_o
);
  import plr_pkg::*;

  localparam int unsigned MUL_W = ACC_W + 4;
  localparam logic [ACC_W-1:0] TOP_PORT = ACC_W'(PORT_COUNT - 1);

  logic             is_digit;
  logic             is_blank;
  logic             is_sep;
  logic             is_dash;
  logic [ACC_W-1:0] dval;
  logic [ACC_W-1:0] mul_src;
  logic [MUL_W-1:0] mul_v;
  logic             over;

  logic [2:0]       n_phase;
  logic [ACC_W-1:0] n_sacc;
  logic [ACC_W-1:0] n_eacc;
  logic             n_fail;
  logic             sep_emit;
  logic [ACC_W-1:0] sep_first;
  logic [ACC_W-1:0] sep_last;
  logic [ACC_W-1:0] fin_first;
  logic [ACC_W-1:0] fin_last;
  logic             fin_fail;
  plr_result_t      sep_res;
  plr_result_t      fin_res;

  assign is_digit = char_i inside {[CH_ZERO:CH_NINE]};
  assign is_blank = (char_i == CH_SPACE) || (char_i == CH_TAB);
  assign is_sep   = (char_i == sep_char_i);
  assign is_dash  = (char_i == CH_DASH);
  assign dval     = ACC_W'(char_i[3:0]);

  assign mul_src = (phase_i == PH_LAST) ? eacc_i : sacc_i;
  assign mul_v   = (MUL_W'(mul_src) << 3) + (MUL_W'(mul_src) << 1) + MUL_W'(char_i[3:0]);
  assign over    = mul_v > MUL_W'(TOP_PORT);

  always_comb begin
    n_phase   = phase_i;
    n_sacc    = sacc_i;
    n_eacc    = eacc_i;
    n_fail    = failed_i;
    sep_emit  = 1'b0;
    sep_first = sacc_i;
    sep_last  = sacc_i;
    if (!failed_i) begin
      case (phase_i)
        PH_FIRST: begin
          if (is_digit) begin
            if (over) n_fail = 1'b1;
            else n_sacc = mul_v[ACC_W-1:0];
          end else if (is_sep) begin
            sep_emit = 1'b1;
            n_phase  = PH_SEP;
          end else if (is_dash) begin
            n_phase = PH_DASH;
          end else if (is_blank) begin
            n_phase = PH_FIRST_SP;
          end else begin
            n_fail = 1'b1;
          end
        end
        PH_FIRST_SP: begin
          if (is_sep) begin
            sep_emit = 1'b1;
            n_phase  = PH_SEP;
          end else if (is_dash) begin
            n_phase = PH_DASH;
          end else if (!is_blank) begin
            n_fail = 1'b1;
          end
        end
        PH_DASH: begin
          if (is_digit) begin
            n_eacc  = dval;
            n_phase = PH_LAST;
          end else if (is_sep) begin
            sep_emit = 1'b1;
            sep_last = TOP_PORT;
            n_phase  = PH_SEP;
          end else if (!is_blank) begin
            n_fail = 1'b1;
          end
        end
        PH_LAST, PH_LAST_SP: begin
          if (is_digit && (phase_i == PH_LAST)) begin
            if (over) n_fail = 1'b1;
            else n_eacc = mul_v[ACC_W-1:0];
          end else if (is_sep) begin
            if (sacc_i <= eacc_i) begin
              sep_emit = 1'b1;
              sep_last = eacc_i;
              n_phase  = PH_SEP;
            end else begin
              n_fail = 1'b1;
            end
          end else if (is_blank) begin
            n_phase = PH_LAST_SP;
          end else begin
            n_fail = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            n_sacc  = dval;
            n_phase = PH_FIRST;
          end else if (is_dash) begin
            n_sacc  = '0;
            n_phase = PH_DASH;
          end else if (!is_blank) begin
            n_fail = 1'b1;
          end
        end
      endcase
    end

    fin_first = '0;
    fin_last  = '0;
    fin_fail  = n_fail;
    if (!n_fail) begin
      case (n_phase)
        PH_FIRST, PH_FIRST_SP: begin
          fin_first = n_sacc;
          fin_last  = n_sacc;
        end
        PH_DASH: begin
          fin_first = n_sacc;
          fin_last  = TOP_PORT;
        end
        PH_LAST, PH_LAST_SP: begin
          if (n_sacc <= n_eacc) begin
            fin_first = n_sacc;
            fin_last  = n_eacc;
          end else begin
            fin_fail = 1'b1;
          end
        end
        PH_SEP: begin
          fin_fail = 1'b1;
        end
        default: begin
          fin_first = '0;
          fin_last  = TOP_PORT;
        end
      endcase
    end
  end

  always_comb begin
    sep_res.first = RANGE_W'(sep_first);
    sep_res.last  = RANGE_W'(sep_last);
    sep_res.valid = 1'b1;
    sep_res.err   = 1'b0;
    sep_res.done  = 1'b0;
    fin_res.first = fin_fail ? '0 : RANGE_W'(fin_first);
    fin_res.last  = fin_fail ? '0 : RANGE_W'(fin_last);
    fin_res.valid = !fin_fail;
    fin_res.err   = fin_fail;
    fin_res.done  = 1'b1;
  end

  assign res0_o    = sep_emit ? sep_res : fin_res;
  assign res1_o    = fin_res;
  assign res_cnt_o = {1'b0, sep_emit} + {1'b0, eot_i};

  assign phase_o  = eot_i ? PH_INIT : n_phase;
  assign sacc_o   = eot_i ? '0 : n_sacc;
  assign eacc_o   = eot_i ? '0 : n_eacc;
  assign failed_o = eot_i ? 1'b0 : n_fail;

endmodule

`default_nettype wire

// File: rtl/core/plr_fifo.sv
// Port list range parser: small result queue, up to two writes per cycle.
// Depends on plr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plr_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           push_cnt_i,
  input  wire plr_pkg::plr_result_t push0_i,
  input  wire plr_pkg::plr_result_t push1_i,
  input  wire logic                 pop_i,
  output      logic                 room2_o,
  output      logic                 not_empty_o,
  output      plr_pkg::plr_result_t head_o
);
  import plr_pkg::*;

  plr_result_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop_i);
  assign cnt_d    = cnt_q + FIFO_CNT_W'(push_cnt_i) - FIFO_CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push1_i;
    end
  end

  assign room2_o     = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign not_empty_o = cnt_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/core/port_list_range_parser_top.sv
// Port list range parser: top level with input register, parse state and result queue.
// Depends on plr_pkg, plr_apb_regs, plr_step and plr_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Takes a port-list text one character per beat and gives one inclusive port
// range per entry; a final beat with list_done set carries the last range or,
// for a malformed list, an error. An input beat is taken every cycle unless
// the input is stalled; it is captured in the input register, then the parse
// step runs and its results (at most two, when a separator is also the last
// character) enter a four-deep result queue. The input stalls only while the
// queue cannot take two more results, which with a steady output keeps one
// character per cycle. The separator character sits at byte address 0 of the
// register port; the user must write it only while the block is idle, and the
// block itself does not enforce this.
module port_list_range_parser_top #(
  parameter int unsigned PORT_COUNT = plr_pkg::PLR_PORT_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [plr_pkg::PLR_ADDR_W-1:0] paddr,
  input  wire logic [plr_pkg::PLR_DATA_W-1:0] pwdata,
  output      logic [plr_pkg::PLR_DATA_W-1:0] prdata,
  output      logic                           pready,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [7:0]                     text_char_i,
  input  wire logic                           end_of_text_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [plr_pkg::RANGE_W-1:0]    range_first_o,
  output      logic [plr_pkg::RANGE_W-1:0]    range_last_o,
  output      logic                           range_valid_o,
  output      logic                           parse_error_o,
  output      logic                           list_done_o
);
  import plr_pkg::*;

  localparam int unsigned ACC_W = $clog2(PORT_COUNT);

  logic [7:0]       sep_char;
  logic             in_vld_q;
  logic [7:0]       char_q;
  logic             eot_q;
  logic             room2;
  logic             proc_go;

  logic [2:0]       phase_q, phase_d;
  logic [ACC_W-1:0] sacc_q, sacc_d;
  logic [ACC_W-1:0] eacc_q, eacc_d;
  logic             failed_q, failed_d;
  logic [1:0]       res_cnt;
  logic [1:0]       push_cnt;
  plr_result_t      res0;
  plr_result_t      res1;
  plr_result_t      head;
  logic             not_empty;

  plr_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sep_char_o (sep_char)
  );

  assign proc_go    = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= text_char_i;
      eot_q  <= end_of_text_i;
    end
  end

  plr_step #(
    .PORT_COUNT (PORT_COUNT),
    .ACC_W      (ACC_W)
  ) u_step (
    .phase_i    (phase_q),
    .sacc_i     (sacc_q),
    .eacc_i     (eacc_q),
    .failed_i   (failed_q),
    .char_i     (char_q),
    .eot_i      (eot_q),
    .sep_char_i (sep_char),
    .phase_o    (phase_d),
    .sacc_o     (sacc_d),
    .eacc_o     (eacc_d),
    .failed_o   (failed_d),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      sacc_q   <= '0;
      eacc_q   <= '0;
      failed_q <= 1'b0;
    end else if (proc_go) begin
      phase_q  <= phase_d;
      sacc_q   <= sacc_d;
      eacc_q   <= eacc_d;
      failed_q <= failed_d;
    end
  end

  assign push_cnt = proc_go ? res_cnt : 2'd0;

  plr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (not_empty && !out_stall_i),
    .room2_o     (room2),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  assign out_valid_o   = not_empty;
  assign range_first_o = head.first;
  assign range_last_o  = head.last;
  assign range_valid_o = head.valid;
  assign parse_error_o = head.err;
  assign list_done_o   = head.done;

endmodule

`default_nettype wire
